// File: rtl/mtd_pkg.sv
// Shared types and constants for the minimum-tracking deque.
package mtd_pkg;

    localparam int DATA_W = 32;

    // empty-queue minimum
    localparam logic signed [DATA_W-1:0] EMPTY_MIN = 32'sd1000000000;

    // operation codes
    localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_BACK   = 2'd2;
    localparam logic [1:0] OP_POP_FRONT  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // datapath commands
    typedef enum logic [3:0] {
        DC_NONE,
        DC_LATCH,
        DC_ERR_FULL,
        DC_ERR_EMPTY,
        DC_PUSH_BACK,
        DC_PUSH_FRONT,
        DC_POP_BACK,
        DC_POP_FRONT,
        DC_LOAD_BMIN,
        DC_LOAD_FMIN,
        DC_DROP_BACK,
        DC_DROP_FRONT,
        DC_DROP_LAST_F,
        DC_DROP_LAST_B,
        DC_SPLIT,
        DC_WR_B
    } t_dp_code;

    typedef struct packed {
        t_dp_code code;
        logic     wr_f;    // front-stack sweep write (code is DC_NONE then)
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       f_zero;
        logic       f_one;
        logic       b_zero;
        logic       b_one;
        logic       idx_last;
        logic       idx_zero;
    } t_dp_status;

endpackage

// File: rtl/mtd_ctrl.sv
// Controller state machine: sequences pushes, pops and stack rebalancing.
module mtd_ctrl import mtd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy,
    output logic       o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_LOAD_B,
        S_LOAD_F,
        S_RD_B,
        S_WR_B,
        S_RD_F,
        S_WR_F
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_done;

    always_comb begin
        o_cmd      = '{code: DC_NONE, wr_f: 1'b0};
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.code = DC_LATCH;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                case (i_status.op)
                    OP_PUSH_BACK, OP_PUSH_FRONT: begin
                        if (i_status.full) begin
                            o_cmd.code = DC_ERR_FULL;
                        end else if (i_status.op == OP_PUSH_BACK) begin
                            o_cmd.code = DC_PUSH_BACK;
                        end else begin
                            o_cmd.code = DC_PUSH_FRONT;
                        end
                    end
                    OP_POP_BACK: begin
                        if (i_status.empty) begin
                            o_cmd.code = DC_ERR_EMPTY;
                        end else if (!i_status.b_zero && !i_status.b_one) begin
                            o_cmd.code = DC_POP_BACK;
                            n_state    = S_LOAD_B;
                        end else if (i_status.b_one) begin
                            o_cmd.code = DC_DROP_BACK;
                        end else if (i_status.f_one) begin
                            o_cmd.code = DC_DROP_LAST_F;
                        end else begin
                            o_cmd.code = DC_SPLIT;
                            n_state    = S_RD_B;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (i_status.empty) begin
                            o_cmd.code = DC_ERR_EMPTY;
                        end else if (!i_status.f_zero && !i_status.f_one) begin
                            o_cmd.code = DC_POP_FRONT;
                            n_state    = S_LOAD_F;
                        end else if (i_status.f_one) begin
                            o_cmd.code = DC_DROP_FRONT;
                        end else if (i_status.b_one) begin
                            o_cmd.code = DC_DROP_LAST_B;
                        end else begin
                            o_cmd.code = DC_SPLIT;
                            n_state    = S_RD_B;
                        end
                    end
                    default: begin
                        o_cmd.code = DC_NONE;
                    end
                endcase
            end
            S_LOAD_B: begin
                o_cmd.code = DC_LOAD_BMIN;
                n_state    = S_IDLE;
            end
            S_LOAD_F: begin
                o_cmd.code = DC_LOAD_FMIN;
                n_state    = S_IDLE;
            end
            S_RD_B: begin
                n_state = S_WR_B;
            end
            S_WR_B: begin
                o_cmd.code = DC_WR_B;
                n_state    = i_status.idx_last ? S_RD_F : S_RD_B;
            end
            S_RD_F: begin
                n_state = S_WR_F;
            end
            S_WR_F: begin
                o_cmd.wr_f = 1'b1;
                // stacks rebuilt: redo the pop on the refilled side
                n_state    = i_status.idx_zero ? S_DECIDE : S_RD_F;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (r_state != S_IDLE) && (n_state == S_IDLE);
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

endmodule

// File: rtl/mtd_dpath.sv
// Datapath: ring storage, prefix-minimum store, stack counts and sweep logic.
module mtd_dpath import mtd_pkg::*; #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [1:0]               i_operation,
    input  logic signed [DATA_W-1:0] i_value,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic [CW-1:0]            o_count,
    output logic                     o_is_empty,
    output logic [1:0]               o_error
);

    // ring index wrap for a sum below twice the depth
    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] t;
        t = s - (AW+1)'(DEPTH);
        return (s >= (AW+1)'(DEPTH)) ? t[AW-1:0] : s[AW-1:0];
    endfunction

    logic signed [DATA_W-1:0] mem_val [DEPTH];
    logic signed [DATA_W-1:0] mem_pm  [DEPTH];

    logic [AW-1:0]            r_front;
    logic [CW-1:0]            r_fcnt, r_bcnt, r_fsplit, r_idx;
    logic signed [DATA_W-1:0] r_fmin, r_bmin, r_val, r_run, r_rd_val, r_rd_pm;
    logic [1:0]               r_op, r_err;
    logic                     r_first;

    logic [CW-1:0]            w_count, w_cnt_m1, w_cnt_m2, w_half;
    logic [AW-1:0]            a_tail_slot, a_head_slot, a_front_next, a_back_next;
    logic [AW-1:0]            a_sweep, a_pm_rd, a_wr;
    logic signed [DATA_W-1:0] w_new_b, w_new_f, w_run_next, w_pm_wd;
    logic                     w_we_val, w_we_pm;

    assign w_count  = r_fcnt + r_bcnt;
    assign w_cnt_m1 = w_count - CW'(1);
    assign w_cnt_m2 = w_count - CW'(2);
    assign w_half   = w_count >> 1;

    assign a_tail_slot  = wrap((AW+1)'(r_front) + (AW+1)'(w_count[AW-1:0]));
    assign a_head_slot  = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign a_front_next = wrap((AW+1)'(r_front) + (AW+1)'(1));
    assign a_back_next  = wrap((AW+1)'(r_front) + (AW+1)'(w_cnt_m2[AW-1:0]));
    assign a_sweep      = wrap((AW+1)'(r_front) + (AW+1)'(r_idx[AW-1:0]));

    assign w_new_b = (r_bcnt != '0 && r_bmin < r_val) ? r_bmin : r_val;
    assign w_new_f = (r_fcnt != '0 && r_fmin < r_val) ? r_fmin : r_val;
    assign w_run_next = (r_first || r_rd_val < r_run) ? r_rd_val : r_run;

    always_comb begin
        w_we_val = 1'b0;
        w_we_pm  = 1'b0;
        a_wr     = a_sweep;
        w_pm_wd  = w_run_next;
        a_pm_rd  = (i_cmd.code == DC_POP_BACK) ? a_back_next : a_front_next;
        case (i_cmd.code)
            DC_PUSH_BACK: begin
                w_we_val = 1'b1;
                w_we_pm  = 1'b1;
                a_wr     = a_tail_slot;
                w_pm_wd  = w_new_b;
            end
            DC_PUSH_FRONT: begin
                w_we_val = 1'b1;
                w_we_pm  = 1'b1;
                a_wr     = a_head_slot;
                w_pm_wd  = w_new_f;
            end
            DC_WR_B: begin
                w_we_pm = 1'b1;
            end
            default: begin
                w_we_pm = i_cmd.wr_f;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_val) begin
            mem_val[a_wr] <= r_val;
        end
        r_rd_val <= mem_val[a_sweep];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_pm) begin
            mem_pm[a_wr] <= w_pm_wd;
        end
        r_rd_pm <= mem_pm[a_pm_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_fcnt  <= '0;
            r_bcnt  <= '0;
            r_err   <= ERR_NONE;
        end else begin
            case (i_cmd.code)
                DC_LATCH: begin
                    r_op  <= i_operation;
                    r_val <= i_value;
                    r_err <= ERR_NONE;
                end
                DC_ERR_FULL: begin
                    r_err <= ERR_FULL;
                end
                DC_ERR_EMPTY: begin
                    r_err <= ERR_EMPTY;
                end
                DC_PUSH_BACK: begin
                    r_bmin <= w_new_b;
                    r_bcnt <= r_bcnt + CW'(1);
                end
                DC_PUSH_FRONT: begin
                    r_fmin  <= w_new_f;
                    r_front <= a_head_slot;
                    r_fcnt  <= r_fcnt + CW'(1);
                end
                DC_POP_BACK: begin
                    r_bcnt <= r_bcnt - CW'(1);
                end
                DC_POP_FRONT: begin
                    r_front <= a_front_next;
                    r_fcnt  <= r_fcnt - CW'(1);
                end
                DC_LOAD_BMIN: begin
                    r_bmin <= r_rd_pm;
                end
                DC_LOAD_FMIN: begin
                    r_fmin <= r_rd_pm;
                end
                DC_DROP_BACK: begin
                    r_bcnt <= '0;
                end
                DC_DROP_FRONT: begin
                    r_front <= a_front_next;
                    r_fcnt  <= '0;
                end
                DC_DROP_LAST_F: begin
                    r_fcnt <= '0;
                end
                DC_DROP_LAST_B: begin
                    r_front <= a_front_next;
                    r_bcnt  <= '0;
                end
                DC_SPLIT: begin
                    // front keeps the smaller half on a front pop, the larger half else
                    r_fsplit <= (r_op == OP_POP_FRONT) ? w_half : w_count - w_half;
                    r_idx    <= (r_op == OP_POP_FRONT) ? w_half : w_count - w_half;
                    r_first  <= 1'b1;
                end
                DC_WR_B: begin
                    r_run   <= w_run_next;
                    r_first <= o_status.idx_last;
                    if (o_status.idx_last) begin
                        r_bmin <= w_run_next;
                        r_idx  <= r_fsplit - CW'(1);
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                default: begin
                    if (i_cmd.wr_f) begin
                        r_run   <= w_run_next;
                        r_first <= 1'b0;
                        if (o_status.idx_zero) begin
                            r_fmin <= w_run_next;
                            r_fcnt <= r_fsplit;
                            r_bcnt <= w_count - r_fsplit;
                        end else begin
                            r_idx <= r_idx - CW'(1);
                        end
                    end
                end
            endcase
        end
    end

    assign o_status.op       = r_op;
    assign o_status.full     = (w_count == CW'(DEPTH));
    assign o_status.empty    = (w_count == '0);
    assign o_status.f_zero   = (r_fcnt == '0);
    assign o_status.f_one    = (r_fcnt == CW'(1));
    assign o_status.b_zero   = (r_bcnt == '0);
    assign o_status.b_one    = (r_bcnt == CW'(1));
    assign o_status.idx_last = (r_idx == w_cnt_m1);
    assign o_status.idx_zero = (r_idx == '0);

    always_comb begin
        if (r_fcnt == '0 && r_bcnt == '0) begin
            o_min_value = EMPTY_MIN;
        end else if (r_fcnt == '0) begin
            o_min_value = r_bmin;
        end else if (r_bcnt == '0) begin
            o_min_value = r_fmin;
        end else begin
            o_min_value = (r_bmin < r_fmin) ? r_bmin : r_fmin;
        end
    end

    assign o_count    = w_count;
    assign o_is_empty = (w_count == '0);
    assign o_error    = r_err;

endmodule

// File: rtl/min_tracking_deque.sv
// Top level of the minimum-tracking deque: controller plus datapath.
//
// Channel   Direction  Handshake                    Beat fields
// command   in         start high, busy low         i_operation, i_value
// result    out        o_done strobe, one cycle     o_min_value, o_count,
//                                                   o_is_empty, o_error
//
// The deque is two stacks over one ring: the front stack runs from the front
// position backward, the back stack from the split point to the back end.
// Each slot keeps a prefix minimum toward its stack's bottom, so the overall
// minimum is the smaller of the two stack tops (1000000000 when empty).
//
// A push, an error or a pop that empties one side ends in the decide state;
// a pop that reads the next stack top from the prefix-minimum store adds a
// load state. A pop that finds its side empty while the other holds more
// than one entry first rebuilds both stacks, a read and a write state per
// element over the single read port of the value store, then pops as usual.
// Reset is synchronous and active low; it empties the deque at once, the
// stores themselves are not cleared. o_done comes in the cycle when busy has
// dropped; the receiver cannot stall, so nothing is held back.
module min_tracking_deque import mtd_pkg::*; #(
    parameter  int DEPTH = 1024,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_operation,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_min_value,
    output logic [CW-1:0]            o_count,
    output logic                     o_is_empty,
    output logic [1:0]               o_error
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    mtd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    mtd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_min_value (o_min_value),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_error     (o_error)
    );

endmodule

// File: rtl/mtd_checker.sv
// Port-level checker for the minimum-tracking deque, bound to the top level.
module mtd_checker import mtd_pkg::*; #(
    parameter  int DEPTH = 1024,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     o_done,
    input  logic signed [DATA_W-1:0] o_min_value,
    input  logic [CW-1:0]            o_count,
    input  logic                     o_is_empty,
    input  logic [1:0]               o_error
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_is_empty |-> o_min_value == EMPTY_MIN)
        else $error("empty deque reports a non-sentinel minimum");

    a_full_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_error == ERR_FULL |-> o_count == CW'(DEPTH))
        else $error("full error while not full");

endmodule

bind min_tracking_deque mtd_checker #(
    .DEPTH (DEPTH)
) u_mtd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_min_value (o_min_value),
    .o_count     (o_count),
    .o_is_empty  (o_is_empty),
    .o_error     (o_error)
);

// File: sim/tb_min_tracking_deque.sv
// Self-checking testbench for the minimum-tracking deque: directed and random command beats.
module tb_min_tracking_deque;
    timeunit 1ns;
    timeprecision 1ps;
    import mtd_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int CW           = $clog2(DEPTH + 1);
    localparam int ITEMS_TARGET = 1650;
    // Worst legal silence is a full rebuild plus a sender gap.
    localparam int STALL_LIMIT  = 10000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;

    localparam logic signed [DATA_W-1:0] INT_MAX_V = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT_MIN_V = 32'sh8000_0000;

    // One expected result beat.
    typedef struct {
        logic signed [DATA_W-1:0] min_value;
        logic [CW-1:0]            count;
        logic                     is_empty;
        logic [1:0]               error;
    } t_deque_status;

    // Scoreboard: keeps its own copy of the held values in order, front first,
    // and the results still owed by the block, oldest first.
    class deque_tracker;
        logic signed [DATA_W-1:0] held[$];
        t_deque_status            pending[$];
        int mismatches;
        int full_errors;
        int empty_errors;
        int peak_count;

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
        endfunction

        // Applies an accepted command beat and queues the result it must cause.
        function void note_command(logic [1:0] op, logic signed [DATA_W-1:0] val);
            t_deque_status s;
            s.error = ERR_NONE;
            if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
                if (held.size() >= DEPTH) begin
                    s.error = ERR_FULL;
                    full_errors++;
                end else if (op == OP_PUSH_BACK) begin
                    held.insert(held.size(), val);
                end else begin
                    held.insert(0, val);
                end
            end else begin
                if (held.size() == 0) begin
                    s.error = ERR_EMPTY;
                    empty_errors++;
                end else if (op == OP_POP_BACK) begin
                    held.delete(held.size() - 1);
                end else begin
                    held.delete(0);
                end
            end
            // true minimum over held values; sentinel only when nothing is held
            s.min_value = EMPTY_MIN;
            foreach (held[i]) begin
                if (i == 0 || held[i] < s.min_value) s.min_value = held[i];
            end
            s.count    = CW'(held.size());
            s.is_empty = (held.size() == 0);
            if (held.size() > peak_count) peak_count = held.size();
            pending.insert(pending.size(), s);
        endfunction

        // Compares a result beat with the oldest expectation.
        function void check_result(logic signed [DATA_W-1:0] mn, logic [CW-1:0] cnt,
                                   logic emp, logic [1:0] err);
            t_deque_status e;
            if (pending.size() == 0) begin
                flag($sformatf("result with nothing pending: min %0d count %0d %s",
                               mn, cnt, $sformatf("empty %0b err %0d", emp, err)));
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (mn !== e.min_value || cnt !== e.count || emp !== e.is_empty ||
                err !== e.error)
                flag($sformatf("exp min %0d count %0d empty %0b err %0d, %s",
                               e.min_value, e.count, e.is_empty, e.error,
                               $sformatf("got min %0d count %0d empty %0b err %0d",
                                         mn, cnt, emp, err)));
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_operation;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_done;
    logic signed [DATA_W-1:0] o_min_value;
    logic [CW-1:0]            o_count;
    logic                     o_is_empty;
    logic [1:0]               o_error;

    deque_tracker tracker = new();
    int items_sent;
    int burst_left;
    int quiet_cycles;

    min_tracking_deque #(.DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_min_value (o_min_value),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_error     (o_error)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Monitor: all sampling happens at the rising edge, on pre-edge values.
    // The result is checked before the new command is noted; a command can
    // never produce its own result in the cycle it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                tracker.check_result(o_min_value, o_count, o_is_empty, o_error);
            if (start && !busy)
                tracker.note_command(i_operation, i_value);
        end
    end

    // Watchdog: counts edges with neither a command accepted nor a result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles, %0d results pending",
                     quiet_cycles, tracker.pending.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Value mix: mostly full-range random, with the signed extremes, the
    // sentinel and its neighbor, and a narrow band near zero so that ties
    // and duplicate minimums turn up often.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       return INT_MAX_V;
                    1:       return INT_MIN_V;
                    2:       return EMPTY_MIN;
                    3:       return EMPTY_MIN + 1;
                    4:       return 0;
                    default: return -1;
                endcase
            end
            1, 2:    return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    // Presents one command beat from a falling edge and holds it until the
    // rising edge where busy is low. start stays high across back-to-back beats.
    task automatic send_command(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
        @(negedge i_clk);
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Sender idling: bursts of random length, short or long, then a random
    // gap with start low. Long bursts give stretches with no idling.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 20);
        gap = $urandom_range(1, 12);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge i_clk);
    endtask

    task automatic send_push(input logic signed [DATA_W-1:0] val);
        send_command($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, val);
        pace_sender();
    endtask

    task automatic send_pop();
        // value is ignored for pops, so it carries noise
        send_command($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
        pace_sender();
    endtask

    // Random mix with a given push share, until the item count reaches a mark.
    task automatic run_mix(input int push_pct, input int until_items);
        while (items_sent < until_items) begin
            if ($urandom_range(0, 99) < push_pct) send_push(pick_value());
            else send_pop();
        end
    endtask

    initial begin
        start       = 1'b0;
        i_operation = OP_PUSH_BACK;
        i_value     = '0;
        i_rst_n     = 1'b0;
        items_sent  = 0;
        burst_left  = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pops on an empty deque from both ends
        send_command(OP_POP_BACK,  INT_MAX_V);
        send_command(OP_POP_FRONT, INT_MIN_V);
        // extremes and sentinel-valued entries from both ends
        send_command(OP_PUSH_BACK,  INT_MAX_V);
        send_command(OP_PUSH_FRONT, INT_MIN_V);
        send_command(OP_PUSH_BACK,  EMPTY_MIN);
        send_command(OP_PUSH_FRONT, EMPTY_MIN + 1);
        // drain: minimum moves as entries leave each end
        send_command(OP_POP_FRONT, 0);
        send_command(OP_POP_BACK,  0);
        send_command(OP_POP_BACK,  0);
        send_command(OP_POP_FRONT, 0);
        send_command(OP_POP_FRONT, 0);
        // back pops drawing from a front-only fill force a rebuild
        send_command(OP_PUSH_FRONT, 0);
        send_command(OP_PUSH_FRONT, -1);
        send_command(OP_PUSH_FRONT, 7);
        send_command(OP_POP_BACK,  0);
        send_command(OP_POP_BACK,  0);
        send_command(OP_POP_BACK,  0);
        // front pop drawing from a back-only fill, then empty again
        send_command(OP_PUSH_BACK, 5);
        send_command(OP_PUSH_BACK, 5);
        send_command(OP_POP_FRONT, 0);
        send_command(OP_POP_FRONT, 0);
        send_command(OP_POP_BACK,  0);
        pace_sender();

        // Random: balanced mix at shallow depth, where empty pops are common
        run_mix(50, 230);
        // fill to capacity, hit the full case from both ends, pop a few and
        // refill so the full case is reached after rebuilds too
        while (tracker.held.size() < DEPTH) send_push(pick_value());
        repeat (4) send_push(pick_value());
        repeat (3) send_pop();
        while (tracker.held.size() < DEPTH) send_push(pick_value());
        send_command(OP_PUSH_BACK,  INT_MIN_V);
        send_command(OP_PUSH_FRONT, INT_MIN_V);
        pace_sender();
        // pop-heavy mix from a deep deque: repeated rebuilds at large counts
        run_mix(35, ITEMS_TARGET);

        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d command beats; peak occupancy %0d of %0d entries.",
                 items_sent, tracker.peak_count, DEPTH);
        $display("Push-while-full beats %0d, pop-while-empty beats %0d, mismatches %0d.",
                 tracker.full_errors, tracker.empty_errors, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mtd_pkg.sv
rtl/mtd_ctrl.sv
rtl/mtd_dpath.sv
rtl/min_tracking_deque.sv
rtl/mtd_checker.sv
sim/tb_min_tracking_deque.sv
